[rtl/lpd_pkg.sv]
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared constants, codes and item types of the length-prefix deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int unsigned HEADER_BYTES     = 4;
  localparam int unsigned LEN_BYTES        = 4;
  localparam int unsigned RELEASE_OVERHEAD = 4;
  localparam int unsigned HDR_CNT_W        = 3;
  localparam int unsigned WORD_W           = 32;
  localparam int unsigned BYTE_W           = 8;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [WORD_W:0]      word_ext_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [HDR_CNT_W-1:0] hdr_cnt_t;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic {
    CFG_REFUSE_THRESH = 1'b0,
    CFG_ACCEPT_THRESH = 1'b1
  } cfg_idx_t;

  // registered input item, release amount already widened with overhead
  typedef struct packed {
    opcode_t   opcode;
    byte_t     in_byte;
    word_ext_t rel_dec;
  } item_t;

  typedef struct packed {
    byte_t out_byte;
    logic  out_valid;
    logic  out_last;
    logic  empty_frame;
    logic  refusing;
    word_t occupancy_now;
  } result_t;

  // handshake between input register and step stage
  typedef struct packed {
    logic  vld;
    item_t item;
  } stage_t;

endpackage

[rtl/lpd_ifs.sv]
// ----------------------------------------------------------------------------
// lpd_in_if / lpd_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface lpd_in_if;
  import lpd_pkg::*;

  logic  valid;
  logic  ready;
  logic  opcode;
  byte_t in_byte;
  word_t released_length;

  modport source (output valid, output opcode, output in_byte, output released_length,
                  input ready);
  modport sink   (input valid, input opcode, input in_byte, input released_length,
                  output ready);
endinterface

interface lpd_out_if;
  import lpd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  out_valid;
  logic  out_last;
  logic  empty_frame;
  logic  refusing;
  word_t occupancy_now;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  output empty_frame, output refusing, output occupancy_now,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input out_last,
                  input empty_frame, input refusing, input occupancy_now,
                  output ready);
endinterface

[rtl/lpd_in_reg.sv]
// ----------------------------------------------------------------------------
// lpd_in_reg
// Input register stage; forms the release amount plus overhead on entry.
// ----------------------------------------------------------------------------
module lpd_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  lpd_in_if.sink          in_chan,
  input  logic            take,
  output lpd_pkg::stage_t stage
);
  import lpd_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;
  item_t item_nxt;
  logic  accept;

  assign in_chan.ready = !vld_r || take;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_comb begin
    item_nxt.opcode  = opcode_t'(in_chan.opcode);
    item_nxt.in_byte = in_chan.in_byte;
    item_nxt.rel_dec = {1'b0, in_chan.released_length} + word_ext_t'(RELEASE_OVERHEAD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign stage.vld  = vld_r;
  assign stage.item = item_r;

endmodule

[rtl/lpd_core.sv]
// ----------------------------------------------------------------------------
// lpd_core
// Deframer and occupancy state, one step per transfer, and the result register.
// ----------------------------------------------------------------------------
module lpd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  lpd_pkg::cfg_idx_t cfg_idx,
  input  lpd_pkg::word_t    cfg_wdata,
  input  lpd_pkg::stage_t   stage,
  output logic              take,
  lpd_out_if.source         out_chan
);
  import lpd_pkg::*;

  word_t    refuse_th_r;
  word_t    accept_th_r;
  hdr_cnt_t hdr_cnt_r;
  hdr_cnt_t hdr_cnt_nxt;
  word_t    frame_len_r;
  word_t    frame_len_nxt;
  word_t    brem_r;
  word_t    brem_nxt;
  word_t    occ_r;
  word_t    occ_nxt;
  logic     refuse_r;
  logic     refuse_nxt;
  logic     res_vld_r;
  logic     res_vld_nxt;
  result_t  res_r;
  result_t  res_nxt;

  word_t     len_base;
  word_t     len_merged;
  word_ext_t occ_diff;
  logic      hdr_done;

  assign take = stage.vld && (!res_vld_r || out_chan.ready);

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refuse_th_r <= '0;
      accept_th_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_REFUSE_THRESH: refuse_th_r <= cfg_wdata;
        CFG_ACCEPT_THRESH: accept_th_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // header assembly
  always_comb begin
    len_base   = (hdr_cnt_r == '0) ? '0 : frame_len_r;
    len_merged = len_base;
    if ({1'b0, hdr_cnt_r} < (HDR_CNT_W+1)'(LEN_BYTES)) begin
      len_merged = len_base |
                   (word_t'(stage.item.in_byte) << {hdr_cnt_r[1:0], 3'b000});
    end
    hdr_done = ({1'b0, hdr_cnt_r} + 1'b1) >= (HDR_CNT_W+1)'(HEADER_BYTES);
  end

  assign occ_diff = {1'b0, occ_r} - stage.item.rel_dec;

  // step
  always_comb begin
    hdr_cnt_nxt   = hdr_cnt_r;
    frame_len_nxt = frame_len_r;
    brem_nxt      = brem_r;
    occ_nxt       = occ_r;
    res_nxt       = '0;

    case (stage.item.opcode)
      OP_BYTE: begin
        if (occ_r != '1) begin
          occ_nxt = occ_r + 1'b1;
        end
        if (brem_r != '0) begin
          res_nxt.out_byte  = stage.item.in_byte;
          res_nxt.out_valid = 1'b1;
          res_nxt.out_last  = (brem_r == word_t'(1));
          brem_nxt          = brem_r - 1'b1;
        end else begin
          frame_len_nxt = len_merged;
          if (hdr_done) begin
            hdr_cnt_nxt = '0;
            if (len_merged == '0) begin
              res_nxt.empty_frame = 1'b1;
            end else begin
              brem_nxt = len_merged;
            end
          end else begin
            hdr_cnt_nxt = hdr_cnt_r + 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        // zero when release covers occupancy
        if (occ_diff[WORD_W] || occ_diff == '0) begin
          occ_nxt = '0;
        end else begin
          occ_nxt = occ_diff[WORD_W-1:0];
        end
      end
      default: ;
    endcase

    refuse_nxt = refuse_r;
    if (refuse_th_r != '0 && occ_nxt >= refuse_th_r) begin
      refuse_nxt = 1'b1;
    end
    if (accept_th_r != '0 && occ_nxt <= accept_th_r) begin
      refuse_nxt = 1'b0;
    end

    res_nxt.refusing      = refuse_nxt;
    res_nxt.occupancy_now = occ_nxt;
  end

  always_comb begin
    res_vld_nxt = res_vld_r;
    if (take) begin
      res_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r   <= '0;
      frame_len_r <= '0;
      brem_r      <= '0;
      occ_r       <= '0;
      refuse_r    <= 1'b0;
      res_vld_r   <= 1'b0;
    end else begin
      res_vld_r <= res_vld_nxt;
      if (take) begin
        hdr_cnt_r   <= hdr_cnt_nxt;
        frame_len_r <= frame_len_nxt;
        brem_r      <= brem_nxt;
        occ_r       <= occ_nxt;
        refuse_r    <= refuse_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid         = res_vld_r;
  assign out_chan.out_byte      = res_r.out_byte;
  assign out_chan.out_valid     = res_r.out_valid;
  assign out_chan.out_last      = res_r.out_last;
  assign out_chan.empty_frame   = res_r.empty_frame;
  assign out_chan.refusing      = res_r.refusing;
  assign out_chan.occupancy_now = res_r.occupancy_now;

  // payload phase only between complete headers
  a_brem_no_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    brem_r != '0 |-> hdr_cnt_r == '0)
    else $error("payload phase with partial header");

  // last payload byte ends the payload phase
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    take && res_nxt.out_last |=> brem_r == '0)
    else $error("payload left after last byte");

  // a received byte below saturation raises occupancy by one
  a_occ_inc: assert property (@(posedge clk) disable iff (!rst_n)
    take && stage.item.opcode == OP_BYTE && occ_r != '1 |=> occ_r == $past(occ_r) + 1'b1)
    else $error("occupancy did not count byte");

  // the result register reports the state it was built with
  a_res_occ: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> res_r.occupancy_now == occ_r && res_r.refusing == refuse_r)
    else $error("result out of step with state");

  // empty frame and payload byte are exclusive
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r |-> !(res_r.empty_frame && res_r.out_valid))
    else $error("empty frame flagged with payload");

endmodule

[rtl/length_prefix_deframer_flow_ctl_unit.sv]
// ----------------------------------------------------------------------------
// length_prefix_deframer_flow_ctl_unit
// Length-prefixed byte deframer with occupancy-driven refuse flag.
// ----------------------------------------------------------------------------
// Each input transfer (a received byte or a release event) yields exactly one
// result transfer. A 4-byte little-endian length precedes each frame's payload;
// payload bytes pass cut-through with the last one marked, and a zero length
// gives one empty-frame result. Occupancy counts received bytes minus released
// length plus 4, saturating at both ends, and drives a hysteretic refuse flag.
// One transfer per cycle unless results stall: an input register and a
// result register frame a combinational step, and each transfer passes
// through both in that order. While a result waits, the input register
// still takes one more transfer before input stalls.
module length_prefix_deframer_flow_ctl_unit (
  input  logic              clk,
  input  logic              rst_n,
  lpd_in_if.sink            in_chan,
  lpd_out_if.source         out_chan,
  input  logic              cfg_we,
  input  lpd_pkg::cfg_idx_t cfg_idx,
  input  lpd_pkg::word_t    cfg_wdata
);
  import lpd_pkg::*;

  stage_t stage;
  logic   take;

  lpd_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .take    (take),
    .stage   (stage)
  );

  lpd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .stage     (stage),
    .take      (take),
    .out_chan  (out_chan)
  );

endmodule

[tb/lpd_deframe_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_deframe_checker
// Watches the input, result and register ports of the deframer. Every
// accepted input transfer runs through a local deframer and occupancy model
// and the result it predicts is queued. Every accepted result transfer is
// compared field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module lpd_deframe_checker (
  input  logic              clk,
  input  logic              rst_n,
  lpd_in_if                 in_mon,
  lpd_out_if                out_mon,
  input  logic              cfg_we,
  input  lpd_pkg::cfg_idx_t cfg_idx,
  input  lpd_pkg::word_t    cfg_wdata,
  output int                fail_count,
  output int                results_owed,
  output int                n_payload,
  output int                n_frame_end,
  output int                n_empty,
  output int                n_refusing
);
  import lpd_pkg::*;

  word_t    refuse_th;
  word_t    accept_th;
  hdr_cnt_t hdr_pos;
  word_t    frame_len;
  word_t    remaining;
  word_t    occ;
  logic     refuse;
  int       n_results;
  result_t  pending_results[$];

  initial begin
    fail_count   = 0;
    results_owed = 0;
    n_payload    = 0;
    n_frame_end  = 0;
    n_empty      = 0;
    n_refusing   = 0;
    n_results    = 0;
  end

  task automatic report_mismatch(string msg);
    $display("%0t: result %0d: %s", $realtime, n_results, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, word_t got, word_t want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is 0x%0h, want 0x%0h", name, got, want));
    end
  endtask

  function automatic result_t deframe_step(opcode_t op, byte_t b, word_t rel);
    result_t           r;
    logic [WORD_W:0]   dec;
    r = '0;
    if (op == OP_BYTE) begin
      if (occ != '1) occ = occ + 1;
      if (remaining != 0) begin
        r.out_byte  = b;
        r.out_valid = 1'b1;
        r.out_last  = (remaining == 1);
        remaining   = remaining - 1;
      end else begin
        if (hdr_pos == 0) frame_len = '0;
        if (hdr_pos < LEN_BYTES) frame_len = frame_len | (word_t'(b) << (8 * hdr_pos));
        if (hdr_pos + 1 >= HEADER_BYTES) begin
          hdr_pos = '0;
          if (frame_len == 0) r.empty_frame = 1'b1;
          else remaining = frame_len;
        end else begin
          hdr_pos = hdr_pos + 1'b1;
        end
      end
    end else begin
      // release amount plus overhead formed one bit wider, no wrap
      dec = {1'b0, rel} + RELEASE_OVERHEAD;
      if (dec >= {1'b0, occ}) occ = '0;
      else occ = occ - dec[WORD_W-1:0];
    end
    if (refuse_th != 0 && occ >= refuse_th) refuse = 1'b1;
    if (accept_th != 0 && occ <= accept_th) refuse = 1'b0;
    r.refusing      = refuse;
    r.occupancy_now = occ;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      refuse_th = '0;
      accept_th = '0;
      hdr_pos   = '0;
      frame_len = '0;
      remaining = '0;
      occ       = '0;
      refuse    = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_REFUSE_THRESH: refuse_th = cfg_wdata;
          CFG_ACCEPT_THRESH: accept_th = cfg_wdata;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result transfer with nothing predicted");
        end else begin
          want = pending_results.pop_front();
          check_field("out_byte", word_t'(out_mon.out_byte), word_t'(want.out_byte));
          check_field("out_valid", word_t'(out_mon.out_valid), word_t'(want.out_valid));
          check_field("out_last", word_t'(out_mon.out_last), word_t'(want.out_last));
          check_field("empty_frame", word_t'(out_mon.empty_frame), word_t'(want.empty_frame));
          check_field("refusing", word_t'(out_mon.refusing), word_t'(want.refusing));
          check_field("occupancy_now", out_mon.occupancy_now, want.occupancy_now);
        end
        n_results++;
        if (out_mon.out_valid === 1'b1) n_payload++;
        if (out_mon.out_last === 1'b1) n_frame_end++;
        if (out_mon.empty_frame === 1'b1) n_empty++;
        if (out_mon.refusing === 1'b1) n_refusing++;
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_results.push_back(deframe_step(opcode_t'(in_mon.opcode), in_mon.in_byte,
                                               in_mon.released_length));
      end
    end
    results_owed = pending_results.size();
  end

endmodule

[tb/length_prefix_deframer_flow_ctl_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefix_deframer_flow_ctl_unit_test
// Drives the deframer with length-prefixed frames, empty frames, releases of
// all sizes and random noise under a series of refuse/accept threshold
// settings, with random gaps on both channels and a long result stall. A
// separate checker predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module length_prefix_deframer_flow_ctl_unit_test;
  import lpd_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned LONG_HOLD    = 80;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned PHASES       = 14;
  localparam int unsigned PHASE_ITEMS  = 40;

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_idx;
  word_t    cfg_wdata;

  int fail_count;
  int results_owed;
  int n_payload;
  int n_frame_end;
  int n_empty;
  int n_refusing;

  bit no_idle;
  bit long_hold_req;
  int items_sent;
  int settings_used;
  int idle_cycles;

  lpd_in_if  in_chan ();
  lpd_out_if out_chan ();

  length_prefix_deframer_flow_ctl_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  lpd_deframe_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .results_owed (results_owed),
    .n_payload    (n_payload),
    .n_frame_end  (n_frame_end),
    .n_empty      (n_empty),
    .n_refusing   (n_refusing)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // result side: random stalls plus one long hold on request
  initial begin : receiver
    int stall_left;
    stall_left     = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD;
      end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
        stall_left = idle_gap();
      end
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(opcode_t op, byte_t b, word_t rel);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.opcode          <= op;
    in_chan.in_byte         <= b;
    in_chan.released_length <= rel;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_byte(byte_t b);
    send_item(OP_BYTE, b, $urandom());
  endtask

  task automatic send_release(word_t len);
    send_item(OP_RELEASE, byte_t'($urandom()), len);
  endtask

  task automatic send_header(word_t len);
    int k;
    for (k = 0; k < LEN_BYTES; k++) send_byte(len[8*k +: 8]);
  endtask

  task automatic send_frame(word_t len, bit release_after);
    int k;
    send_header(len);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 15) == 0) send_release($urandom_range(0, 20));
      send_byte(byte_t'($urandom()));
    end
    if (release_after) send_release(len);
  endtask

  // sender pauses until every predicted result has arrived
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_thresholds(word_t refuse_at, word_t accept_at);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_REFUSE_THRESH;
    cfg_wdata <= refuse_at;
    @(negedge clk);
    cfg_idx   <= CFG_ACCEPT_THRESH;
    cfg_wdata <= accept_at;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int    ph;
    int    start;
    int    r;
    word_t len;
    word_t refuse_at;
    word_t accept_at;

    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_idx                 = CFG_REFUSE_THRESH;
    cfg_wdata               = '0;
    in_chan.valid           = 1'b0;
    in_chan.opcode          = OP_BYTE;
    in_chan.in_byte         = '0;
    in_chan.released_length = '0;
    no_idle                 = 1'b0;
    long_hold_req           = 1'b0;
    items_sent              = 0;
    settings_used           = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // thresholds disabled after reset
    send_frame(32'd0, 1'b0);
    send_header(32'd1);
    send_byte(8'hFF);
    send_release(32'hFFFF_FFFF);
    send_header(32'd2);
    send_byte(8'h00);
    send_release(32'd0);
    send_byte(8'hFF);

    // refusal is advisory, bytes keep flowing
    set_thresholds(32'd3, 32'd1);
    send_frame(32'd3, 1'b1);

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin refuse_at = '0;               accept_at = '0;               end
        1: begin refuse_at = 32'hFFFF_FFFF;    accept_at = '0;               end
        2: begin refuse_at = 32'd1;            accept_at = '0;               end
        3: begin refuse_at = 32'd1;            accept_at = 32'hFFFF_FFFF;    end
        4: begin refuse_at = 32'hFFFF_FFFF;    accept_at = 32'hFFFF_FFFF;    end
        default: begin
          refuse_at = $urandom_range(1, 48);
          accept_at = $urandom_range(0, refuse_at + 8);
        end
      endcase
      set_thresholds(refuse_at, accept_at);
      no_idle = (ph % 5 == 2) || (ph == 6);
      if (ph == 6) long_hold_req = 1'b1;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          if ($urandom_range(0, 9) == 0) len = $urandom_range(13, 60);
          else len = $urandom_range(0, 12);
          send_frame(len, $urandom_range(0, 9) < 7);
        end else if (r < 90) begin
          send_release($urandom_range(0, 20));
        end else begin
          send_release($urandom());
        end
      end
    end

    // all-ones length: stays in payload from here on
    no_idle = 1'b0;
    set_thresholds(32'd6, 32'd2);
    send_header(32'hFFFF_FFFF);
    repeat (8) send_byte(byte_t'($urandom()));

    in_chan.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("covered %0d input transfers under %0d threshold settings",
             items_sent, settings_used);
    $display("saw %0d payload bytes, %0d frame ends, %0d empty frames, %0d while refusing",
             n_payload, n_frame_end, n_empty, n_refusing);
    if (fail_count == 0 && results_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
